>>> rtl/core/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

    localparam logic [7:0]  SYNC_FIRST     = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND    = 8'h5A;

    localparam logic [15:0] GEN_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_INIT_RESET = 16'h0000;

    localparam int          CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_TYPE,
        PH_CNT_HI,
        PH_CNT_LO,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_GOOD,
        KIND_BAD,
        KIND_LENERR
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  frame_type;
        logic [15:0] payload_len;
    } t_result;

endpackage

>>> rtl/core/sfp_if.sv
`timescale 1ns / 1ps

interface sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if;
    logic               valid;
    logic               ready;
    sfp_pkg::t_kind     kind;
    logic [7:0]         data;
    logic [7:0]         frame_type;
    logic [15:0]        payload_len;

    modport source (output valid, output kind, output data, output frame_type,
                    output payload_len, input ready);
    modport sink   (input valid, input kind, input data, input frame_type,
                    input payload_len, output ready);
endinterface

>>> rtl/core/sfp_crc16.sv
`timescale 1ns / 1ps

module sfp_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_poly,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] r;
        r = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ i_poly;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        o_crc = r;
    end

endmodule

>>> rtl/core/sfp_parser.sv
`timescale 1ns / 1ps

module sfp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic [15:0]         i_gen_poly,
    input  logic [15:0]         i_crc_init,
    output sfp_pkg::t_result    o_result
);

    sfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_type, n_type;
    logic [15:0]     r_count, n_count;
    logic [15:0]     r_remaining, n_remaining;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_crc_high, n_crc_high;

    logic [15:0]     crc_base;
    logic [15:0]     crc_next;
    logic [15:0]     cnt_lo_val;
    logic [15:0]     rem_dec;
    logic [15:0]     len;

    assign crc_base = (r_phase == sfp_pkg::PH_HUNT ||
                       (r_phase == sfp_pkg::PH_SYNC2 && i_byte != sfp_pkg::SYNC_SECOND))
                      ? i_crc_init : r_crc;

    sfp_crc16 u_crc (
        .i_crc  (crc_base),
        .i_byte (i_byte),
        .i_poly (i_gen_poly),
        .o_crc  (crc_next)
    );

    assign cnt_lo_val = {r_count[15:8], i_byte};
    assign rem_dec    = (r_remaining != 16'd0) ? 16'(r_remaining - 16'd1) : r_remaining;
    assign len        = (r_count >= 16'd2) ? 16'(r_count - 16'd2) : 16'd0;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_count     = r_count;
        n_remaining = r_remaining;
        n_crc       = r_crc;
        n_crc_high  = r_crc_high;
        unique case (r_phase)
            sfp_pkg::PH_HUNT: begin
                if (i_byte == sfp_pkg::SYNC_FIRST) begin
                    n_crc   = crc_next;
                    n_phase = sfp_pkg::PH_SYNC2;
                end
            end
            sfp_pkg::PH_SYNC2: begin
                if (i_byte == sfp_pkg::SYNC_SECOND) begin
                    n_crc   = crc_next;
                    n_phase = sfp_pkg::PH_TYPE;
                end else if (i_byte == sfp_pkg::SYNC_FIRST) begin
                    n_crc   = crc_next;
                end else begin
                    n_phase = sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_TYPE: begin
                n_type  = i_byte;
                n_crc   = crc_next;
                n_phase = sfp_pkg::PH_CNT_HI;
            end
            sfp_pkg::PH_CNT_HI: begin
                n_count = {i_byte, 8'h00};
                n_crc   = crc_next;
                n_phase = sfp_pkg::PH_CNT_LO;
            end
            sfp_pkg::PH_CNT_LO: begin
                n_count = cnt_lo_val;
                n_crc   = crc_next;
                if (cnt_lo_val < 16'd2) begin
                    n_phase = sfp_pkg::PH_HUNT;
                end else begin
                    n_remaining = 16'(cnt_lo_val - 16'd2);
                    n_phase     = (cnt_lo_val == 16'd2) ? sfp_pkg::PH_CRC_HI
                                                        : sfp_pkg::PH_PAYLOAD;
                end
            end
            sfp_pkg::PH_PAYLOAD: begin
                n_crc       = crc_next;
                n_remaining = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_phase = sfp_pkg::PH_CRC_HI;
                end
            end
            sfp_pkg::PH_CRC_HI: begin
                n_crc_high = i_byte;
                n_phase    = sfp_pkg::PH_CRC_LO;
            end
            sfp_pkg::PH_CRC_LO: begin
                n_phase = sfp_pkg::PH_HUNT;
            end
            default: begin
                n_phase = sfp_pkg::PH_HUNT;
            end
        endcase
    end

    // result
    always_comb begin
        o_result             = '0;
        o_result.frame_type  = r_type;
        o_result.payload_len = len;
        o_result.kind        = sfp_pkg::KIND_DATA;
        unique case (r_phase)
            sfp_pkg::PH_CNT_LO: begin
                if (cnt_lo_val < 16'd2) begin
                    o_result.valid       = i_step;
                    o_result.kind        = sfp_pkg::KIND_LENERR;
                    o_result.payload_len = 16'd0;
                end
            end
            sfp_pkg::PH_PAYLOAD: begin
                o_result.valid = i_step;
                o_result.data  = i_byte;
            end
            sfp_pkg::PH_CRC_LO: begin
                o_result.valid = i_step;
                o_result.kind  = ({r_crc_high, i_byte} == r_crc) ? sfp_pkg::KIND_GOOD
                                                                 : sfp_pkg::KIND_BAD;
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfp_pkg::PH_HUNT;
            r_type      <= 8'h00;
            r_count     <= 16'd0;
            r_remaining <= 16'd0;
            r_crc       <= sfp_pkg::CRC_INIT_RESET;
            r_crc_high  <= 8'h00;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_crc       <= n_crc;
            r_crc_high  <= n_crc_high;
        end
    end

endmodule

>>> rtl/core/sync_frame_parser_crc16_core.sv
`timescale 1ns / 1ps

// Frame deframer: hunts for the A5 5A sync pair, reads a type byte and a
// big-endian count (payload length plus 2), streams payload words tagged with
// the type, then checks the big-endian trailing CRC-16 (MSB-first, generator
// polynomial register, seeded with the init register) and reports good, bad or
// length error. One rx word is taken every cycle while the result side is not
// stalled; each word passes through an input register, the parse logic whose
// longest path is the 8-step bytewise CRC update and, if it yields a result,
// the result register. A stalled result holds the input off. Write the
// registers only while no word is in flight.

module sync_frame_parser_crc16_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                     i_cfg_data,
    sfp_byte_if.sink                        i_rx,
    sfp_result_if.source                    o_frm
);

    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic [15:0]       r_gen_poly;
    logic [15:0]       r_crc_init;
    logic              r_out_valid;
    sfp_pkg::t_result  r_out;
    sfp_pkg::t_result  res;
    logic              s1_fire;

    assign s1_fire    = r_s1_valid && (!r_out_valid || o_frm.ready);
    assign i_rx.ready = !r_s1_valid || !r_out_valid || o_frm.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_poly <= sfp_pkg::GEN_POLY_RESET;
            r_crc_init <= sfp_pkg::CRC_INIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfp_pkg::REG_GEN_POLY: r_gen_poly <= i_cfg_data;
                sfp_pkg::REG_CRC_INIT: r_crc_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_s1_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    sfp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_fire),
        .i_byte     (r_s1_byte),
        .i_gen_poly (r_gen_poly),
        .i_crc_init (r_crc_init),
        .o_result   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= res.valid;
        end else if (o_frm.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res.valid) begin
            r_out <= res;
        end
    end

    assign o_frm.valid       = r_out_valid;
    assign o_frm.kind        = r_out.kind;
    assign o_frm.data        = r_out.data;
    assign o_frm.frame_type  = r_out.frame_type;
    assign o_frm.payload_len = r_out.payload_len;

endmodule

>>> rtl/core/sfp_checker.sv
`timescale 1ns / 1ps

module sfp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  sfp_pkg::t_kind  i_kind,
    input  logic [7:0]      i_data,
    input  logic [15:0]     i_payload_len
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_data) && $stable(i_payload_len))
        else $error("result word dropped or changed while stalled");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != sfp_pkg::KIND_DATA |-> i_data == 8'h00)
        else $error("nonzero data on a frame end word");

    a_lenerr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == sfp_pkg::KIND_LENERR |-> i_payload_len == 16'd0)
        else $error("length error with nonzero payload length");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind sync_frame_parser_crc16_core sfp_checker u_sfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_frm.valid),
    .i_out_ready   (o_frm.ready),
    .i_kind        (o_frm.kind),
    .i_data        (o_frm.data),
    .i_payload_len (o_frm.payload_len)
);

>>> test/sfp_frame_checker.sv
`timescale 1ns / 1ps

module sfp_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_data,
    sfp_byte_if                           i_rx,
    sfp_result_if                         i_frm,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct {
        sfp_pkg::t_kind kind;
        logic [7:0]     data;
        logic [7:0]     frame_type;
        logic [15:0]    payload_len;
    } t_frm_word;

    t_frm_word   frm_expect_q[$];
    t_frm_word   got_exp;

    sfp_pkg::t_phase ph;
    logic [7:0]  type_q;
    logic [15:0] count_q;
    logic [15:0] remain_q;
    logic [15:0] crc_q;
    logic [7:0]  crc_hi_q;
    logic [15:0] poly_q;
    logic [15:0] init_q;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ poly_q) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [15:0] frame_len();
        return (count_q >= 16'd2) ? count_q - 16'd2 : 16'd0;
    endfunction

    task automatic push_expect(input sfp_pkg::t_kind kind, input logic [7:0] data,
                               input logic [15:0] len);
        t_frm_word w;
        w.kind        = kind;
        w.data        = data;
        w.frame_type  = type_q;
        w.payload_len = len;
        frm_expect_q.push_back(w);
    endtask

    // one rx word through the deframer state machine
    task automatic parse_rx_word(input logic [7:0] b);
        case (ph)
            sfp_pkg::PH_HUNT: begin
                if (b == sfp_pkg::SYNC_FIRST) begin
                    crc_q = crc16_next(init_q, b);
                    ph    = sfp_pkg::PH_SYNC2;
                end
            end
            sfp_pkg::PH_SYNC2: begin
                if (b == sfp_pkg::SYNC_SECOND) begin
                    crc_q = crc16_next(crc_q, b);
                    ph    = sfp_pkg::PH_TYPE;
                end else if (b == sfp_pkg::SYNC_FIRST) begin
                    crc_q = crc16_next(init_q, b);
                end else begin
                    ph = sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_TYPE: begin
                type_q = b;
                crc_q  = crc16_next(crc_q, b);
                ph     = sfp_pkg::PH_CNT_HI;
            end
            sfp_pkg::PH_CNT_HI: begin
                count_q = {b, 8'h00};
                crc_q   = crc16_next(crc_q, b);
                ph      = sfp_pkg::PH_CNT_LO;
            end
            sfp_pkg::PH_CNT_LO: begin
                count_q[7:0] = b;
                crc_q        = crc16_next(crc_q, b);
                if (count_q < 16'd2) begin
                    ph = sfp_pkg::PH_HUNT;
                    push_expect(sfp_pkg::KIND_LENERR, 8'h00, 16'd0);
                end else begin
                    remain_q = count_q - 16'd2;
                    ph       = (remain_q == 16'd0) ? sfp_pkg::PH_CRC_HI
                                                   : sfp_pkg::PH_PAYLOAD;
                end
            end
            sfp_pkg::PH_PAYLOAD: begin
                crc_q = crc16_next(crc_q, b);
                if (remain_q != 16'd0) begin
                    remain_q = remain_q - 16'd1;
                end
                if (remain_q == 16'd0) begin
                    ph = sfp_pkg::PH_CRC_HI;
                end
                push_expect(sfp_pkg::KIND_DATA, b, frame_len());
            end
            sfp_pkg::PH_CRC_HI: begin
                crc_hi_q = b;
                ph       = sfp_pkg::PH_CRC_LO;
            end
            default: begin
                ph = sfp_pkg::PH_HUNT;
                push_expect(({crc_hi_q, b} == crc_q) ? sfp_pkg::KIND_GOOD
                                                     : sfp_pkg::KIND_BAD,
                            8'h00, frame_len());
            end
        endcase
    endtask

    task automatic match_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph       = sfp_pkg::PH_HUNT;
            type_q   = 8'h00;
            count_q  = 16'd0;
            remain_q = 16'd0;
            crc_q    = sfp_pkg::CRC_INIT_RESET;
            crc_hi_q = 8'h00;
            poly_q   = sfp_pkg::GEN_POLY_RESET;
            init_q   = sfp_pkg::CRC_INIT_RESET;
            frm_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == sfp_pkg::REG_GEN_POLY) begin
                    poly_q = i_cfg_data;
                end else if (i_cfg_idx == sfp_pkg::REG_CRC_INIT) begin
                    init_q = i_cfg_data;
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                parse_rx_word(i_rx.rx_byte);
            end
            if (i_frm.valid && i_frm.ready) begin
                if (frm_expect_q.size() == 0) begin
                    $error("unexpected frm word: kind %0d data %0d type %0d len %0d",
                           i_frm.kind, i_frm.data, i_frm.frame_type, i_frm.payload_len);
                    o_fail_count++;
                end else begin
                    got_exp = frm_expect_q.pop_front();
                    match_field("kind", got_exp.kind, i_frm.kind);
                    match_field("data", got_exp.data, i_frm.data);
                    match_field("frame_type", got_exp.frame_type, i_frm.frame_type);
                    match_field("payload_len", got_exp.payload_len, i_frm.payload_len);
                end
            end
        end
        o_pending = frm_expect_q.size();
    end

    final begin
        if (frm_expect_q.size() != 0) begin
            $error("frm words still expected at end: %0d", frm_expect_q.size());
        end
    end

endmodule

>>> test/tb_sync_frame_parser_crc16_core.sv
`timescale 1ns / 1ps

module tb_sync_frame_parser_crc16_core;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [sfp_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [15:0]                   cfg_data;

    sfp_byte_if   rx_if ();
    sfp_result_if frm_if ();

    int          fail_count;
    int          pending;
    int          sent;
    bit          no_idle;
    logic [15:0] cur_poly;
    logic [15:0] cur_init;
    logic [15:0] tx_crc;

    sync_frame_parser_crc16_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .o_frm      (frm_if)
    );

    sfp_frame_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_rx         (rx_if),
        .i_frm        (frm_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [15:0] frame_crc_next(input logic [15:0] crc,
                                                   input logic [7:0] b,
                                                   input logic [15:0] poly);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ((r << 1) ^ poly) : (r << 1);
        end
        return r;
    endfunction

    // called at a falling edge; valid stays high after the accept so a
    // zero gap keeps the stream back to back
    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_tracked(input logic [7:0] b);
        tx_crc = frame_crc_next(tx_crc, b, cur_poly);
        send_word(b);
    endtask

    task automatic start_frame(input logic [7:0] ftype, input logic [15:0] count);
        tx_crc = cur_init;
        send_tracked(sfp_pkg::SYNC_FIRST);
        send_tracked(sfp_pkg::SYNC_SECOND);
        send_tracked(ftype);
        send_tracked(count[15:8]);
        send_tracked(count[7:0]);
    endtask

    task automatic end_frame(input bit corrupt);
        logic [15:0] crc;
        crc = tx_crc;
        if (corrupt) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_word(crc[15:8]);
        send_word(crc[7:0]);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input int len, input bit corrupt);
        start_frame(ftype, 16'(len + 2));
        for (int i = 0; i < len; i++) begin
            send_tracked(8'($urandom));
        end
        end_frame(corrupt);
    endtask

    // drop valid, wait for all words out, then let the pipeline drain
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic load_crc_regs(input logic [15:0] poly, input logic [15:0] init);
        cfg_we   <= 1'b1;
        cfg_idx  <= sfp_pkg::REG_GEN_POLY;
        cfg_data <= poly;
        @(negedge i_clk);
        cfg_idx  <= sfp_pkg::REG_CRC_INIT;
        cfg_data <= init;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_poly = poly;
        cur_init = init;
    endtask

    // sink side: independent stall before each frm word
    initial begin
        int stall;
        frm_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                frm_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            frm_if.ready <= 1'b1;
            do @(posedge i_clk); while (!frm_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int          sel;
        int          len;
        int          phase_n;
        int          phase_end;
        int          rand_goal;
        logic [7:0]  b;
        logic [15:0] poly;
        logic [15:0] init;

        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        cfg_we        = 1'b0;
        cfg_idx       = sfp_pkg::REG_GEN_POLY;
        cfg_data      = 16'h0000;
        cur_poly      = sfp_pkg::GEN_POLY_RESET;
        cur_init      = sfp_pkg::CRC_INIT_RESET;
        tx_crc        = sfp_pkg::CRC_INIT_RESET;
        sent          = 0;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: broken sync, sync restart, empty payload, length errors, bad CRC
        send_word(8'hA5);
        send_word(8'h13);
        send_word(8'hA5);
        send_frame(8'h00, 0, 1'b0);
        start_frame(8'hFF, 16'h0000);
        start_frame(8'h80, 16'h0001);
        start_frame(8'h3C, 16'h0004);
        send_tracked(8'h00);
        send_tracked(8'hFF);
        end_frame(1'b1);

        // regs rewritten mid-frame: poly takes effect now, init next frame
        start_frame(8'h5A, 16'h0004);
        send_tracked(8'h55);
        settle();
        load_crc_regs(16'h8005, 16'hFFFF);
        send_tracked(8'hAA);
        end_frame(1'b0);
        send_frame(8'hC3, 1, 1'b0);

        rand_goal = sent + 850;
        phase_n   = 0;
        while (sent < rand_goal) begin
            settle();
            case (phase_n % 4)
                0: begin
                    poly = 16'($urandom);
                    init = 16'($urandom);
                end
                1: begin
                    poly = 16'hFFFF;
                    init = 16'hFFFF;
                end
                2: begin
                    poly = 16'h0000;
                    init = 16'h0000;
                end
                default: begin
                    poly = 16'h1021;
                    init = 16'($urandom);
                end
            endcase
            load_crc_regs(poly, init);
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_end = sent + 110;
            while (sent < phase_end && sent < rand_goal) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    len = ($urandom_range(0, 49) == 0) ? $urandom_range(64, 300)
                                                       : $urandom_range(0, 12);
                    send_frame(8'($urandom), len, 1'b0);
                end else if (sel < 77) begin
                    send_frame(8'($urandom), $urandom_range(0, 12), 1'b1);
                end else if (sel < 84) begin
                    start_frame(8'($urandom), 16'($urandom_range(0, 1)));
                end else if (sel < 92) begin
                    repeat ($urandom_range(1, 5)) begin
                        b = 8'($urandom);
                        send_word((b == sfp_pkg::SYNC_FIRST) ? ~b : b);
                    end
                end else begin
                    b = 8'($urandom);
                    send_word(sfp_pkg::SYNC_FIRST);
                    send_word((b == sfp_pkg::SYNC_SECOND) ? ~b : b);
                end
            end
            phase_n++;
        end
        no_idle = 1'b0;

        settle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sync_frame_parser_crc16_core.f
rtl/core/sfp_pkg.sv
rtl/core/sfp_if.sv
rtl/core/sfp_crc16.sv
rtl/core/sfp_parser.sv
rtl/core/sync_frame_parser_crc16_core.sv
rtl/core/sfp_checker.sv
test/sfp_frame_checker.sv
test/tb_sync_frame_parser_crc16_core.sv
